// ----- design/status_led_blink_sequencer_macros.svh -----
// Assertion macros shared by the status LED blink sequencer modules.
`ifndef STATUS_LED_BLINK_SEQUENCER_MACROS_SVH
`define STATUS_LED_BLINK_SEQUENCER_MACROS_SVH

`ifndef SYNTH
`define SLBS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("slbs assertion failed");
`define SLBS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("slbs assertion failed");
`else
`define SLBS_ASSERT_NOW(label, clk, rst, pre, post)
`define SLBS_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ----- design/slbs_pkg.sv -----
`timescale 1ns / 1ps

package slbs_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int TIMER_W     = 16;
   localparam int COUNT_W     = 8;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam logic [TIMER_W-1:0] BLINK_INTERVAL_RESET = 16'd100;
   localparam logic [TIMER_W-1:0] CONNECT_PULSE_RESET  = 16'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLINK_INTERVAL = 2'd0,
      CSR_CONNECT_PULSE  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [TIMER_W-1:0] blink_interval_ms;
      logic [TIMER_W-1:0] connect_pulse_ms;
   } cfg_type;

   typedef struct packed {
      logic [7:0] elapsed_ms;
      logic [7:0] mode_number;
      logic       link_connected;
   } tick_type;

   typedef struct packed {
      logic [COUNT_W-1:0] blinks_left;
      logic               led_on;
   } result_type;

   function automatic logic [TIMER_W-1:0] sat_sub(input logic [TIMER_W-1:0] t,
                                                  input logic [7:0] d);
      logic [TIMER_W-1:0] dz;
      dz = {{(TIMER_W-8){1'b0}}, d};
      return (t > dz) ? (t - dz) : '0;
   endfunction

endpackage

// ----- design/slbs_csr.sv -----
`timescale 1ns / 1ps

module slbs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [slbs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slbs_pkg::CSR_DATA_W-1:0]  csr_data,
   output slbs_pkg::cfg_type             cfg
);
   import slbs_pkg::*;

   logic [TIMER_W-1:0] blink_interval_ff, blink_interval_in;
   logic [TIMER_W-1:0] connect_pulse_ff, connect_pulse_in;
   logic               wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // indexes past the register list fall through and are dropped
   always_comb begin
      blink_interval_in = blink_interval_ff;
      connect_pulse_in  = connect_pulse_ff;
      if (wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BLINK_INTERVAL: blink_interval_in = csr_data;
            CSR_CONNECT_PULSE:  connect_pulse_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_interval_ff <= BLINK_INTERVAL_RESET;
         connect_pulse_ff  <= CONNECT_PULSE_RESET;
      end else begin
         blink_interval_ff <= blink_interval_in;
         connect_pulse_ff  <= connect_pulse_in;
      end
   end

   assign cfg.blink_interval_ms = blink_interval_ff;
   assign cfg.connect_pulse_ms  = connect_pulse_ff;

endmodule

// ----- design/slbs_tick.sv -----
`timescale 1ns / 1ps
`include "status_led_blink_sequencer_macros.svh"

module slbs_tick (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_en,
   input  slbs_pkg::tick_type   tick,
   input  slbs_pkg::cfg_type    cfg,
   output slbs_pkg::result_type result
);
   import slbs_pkg::*;

   logic               primed_ff, primed_in;
   logic [7:0]         last_mode_ff, last_mode_in;
   logic [COUNT_W-1:0] pending_ff, pending_in;
   logic               link_seen_ff, link_seen_in;
   logic [TIMER_W-1:0] on_timer_ff, on_timer_in;
   logic [TIMER_W-1:0] off_timer_ff, off_timer_in;
   logic               led_ff, led_in;

   logic [7:0]         base_mode;
   logic               mode_chg;
   logic               link_chg;
   logic               blink_start;
   logic [TIMER_W-1:0] on_mid;
   logic [TIMER_W-1:0] off_mid;
   logic [COUNT_W-1:0] pending_mid;
   logic [TIMER_W-1:0] on_dec;

   always_comb begin
      // first tick latches the mode without blinking
      base_mode = primed_ff ? last_mode_ff : tick.mode_number;
      mode_chg  = base_mode != tick.mode_number;
      link_chg  = tick.link_connected != link_seen_ff;

      off_mid     = off_timer_ff;
      pending_mid = pending_ff;
      if (mode_chg) begin
         off_mid     = ((pending_ff != '0) || (on_timer_ff != '0)) ?
                       cfg.blink_interval_ms : '0;
         pending_mid = tick.mode_number;
      end
      on_mid = link_chg ? cfg.connect_pulse_ms : on_timer_ff;

      on_dec      = sat_sub(on_mid, tick.elapsed_ms);
      blink_start = 1'b0;

      primed_in    = 1'b1;
      last_mode_in = tick.mode_number;
      link_seen_in = tick.link_connected;
      on_timer_in  = on_mid;
      off_timer_in = off_mid;
      pending_in   = pending_mid;
      led_in       = led_ff;
      if (on_mid != '0) begin
         on_timer_in = on_dec;
         led_in      = on_dec != '0;
      end else if (off_mid != '0) begin
         off_timer_in = sat_sub(off_mid, tick.elapsed_ms);
      end else if (pending_mid != '0) begin
         blink_start  = 1'b1;
         on_timer_in  = cfg.blink_interval_ms;
         off_timer_in = cfg.blink_interval_ms;
         pending_in   = pending_mid - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         last_mode_ff <= '0;
         pending_ff   <= '0;
         link_seen_ff <= 1'b0;
         on_timer_ff  <= '0;
         off_timer_ff <= '0;
         led_ff       <= 1'b0;
      end else if (tick_en) begin
         primed_ff    <= primed_in;
         last_mode_ff <= last_mode_in;
         pending_ff   <= pending_in;
         link_seen_ff <= link_seen_in;
         on_timer_ff  <= on_timer_in;
         off_timer_ff <= off_timer_in;
         led_ff       <= led_in;
      end
   end

   assign result.led_on      = led_in;
   assign result.blinks_left = pending_in;

   `SLBS_ASSERT_NEXT(a_primed_sticky, clock, reset, primed_ff, primed_ff)
   `SLBS_ASSERT_NOW(a_pending_grows_on_mode, clock, reset,
                    tick_en && (pending_in > pending_ff), mode_chg)
   `SLBS_ASSERT_NOW(a_on_timer_grows_on_start, clock, reset,
                    tick_en && (on_timer_in > on_timer_ff), link_chg || blink_start)
   `SLBS_ASSERT_NEXT(a_led_holds_idle, clock, reset,
                     !tick_en, $stable(led_ff) && $stable(pending_ff))

endmodule

// ----- design/slbs_rsp_reg.sv -----
`timescale 1ns / 1ps
`include "status_led_blink_sequencer_macros.svh"

module slbs_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 tick_en,
   input  slbs_pkg::result_type result,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output slbs_pkg::result_type rsp_result
);
   import slbs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // take a new beat when the register is empty or the held result leaves in the same cycle
   assign req_tready = !valid_ff || rsp_tready;
   assign tick_en    = req_tvalid && req_tready;

   always_comb begin
      valid_in = tick_en || (valid_ff && !rsp_tready);
      data_in  = tick_en ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

   `SLBS_ASSERT_NEXT(a_accept_gives_result, clock, reset, tick_en, valid_ff)
   `SLBS_ASSERT_NOW(a_no_accept_when_full, clock, reset,
                    valid_ff && !rsp_tready, !tick_en)

endmodule

// ----- design/status_led_blink_sequencer.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Content
// req_      in         tdata: elapsed_ms[7:0], mode_number[15:8], link_connected[16]
// rsp_      out        tdata: led_on[0], blinks_left[8:1]
// csr_      in         csr_index selects the register, csr_data carries the value
//
// One result per tick beat, in the cycle after it is accepted; a new beat is
// taken every cycle unless the result is stalled. The tick logic is a single
// pass from the request beat into the result register. Reset is synchronous
// and restores register defaults and cleared state. A stalled result holds
// and blocks only the next beat; csr writes are always taken.

module status_led_blink_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // elapsed_ms [7:0], mode_number [15:8], link_connected [16], zero [23:17]
   input  logic [slbs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // led_on [0], blinks_left [8:1], zero [15:9]
   output logic [slbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slbs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import slbs_pkg::*;

   cfg_type    cfg;
   tick_type   tick;
   result_type result;
   result_type rsp_result;
   logic       tick_en;

   assign tick.elapsed_ms     = req_tdata[7:0];
   assign tick.mode_number    = req_tdata[15:8];
   assign tick.link_connected = req_tdata[16];

   slbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   slbs_tick u_tick (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .tick    (tick),
      .cfg     (cfg),
      .result  (result)
   );

   slbs_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .tick_en    (tick_en),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-COUNT_W-1){1'b0}},
                       rsp_result.blinks_left, rsp_result.led_on};

endmodule
